@@ design/cse_pkg.sv @@
`default_nettype none
package cse_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // instruction bytes
  localparam logic [7:0] OPC_LDA_IMM = 8'h86;
  localparam logic [7:0] OPC_LDA_DIR = 8'h96;
  localparam logic [7:0] OPC_STA_DIR = 8'h97;
  localparam logic [7:0] OPC_LDB_DIR = 8'hd6;
  localparam logic [7:0] OPC_ANDB_IMM = 8'hc4;
  localparam logic [7:0] OPC_STB_DIR = 8'hd7;
  localparam logic [7:0] OPC_BITA_IMM = 8'h85;

  // condition-code bit positions
  localparam int FLAG_N_BIT = 3;
  localparam int FLAG_Z_BIT = 2;
  localparam int SIGN_BIT = 7;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_BAD_OP = 1'b1;

  typedef enum logic [2:0] {
    OP_LDA_IMM,
    OP_LDA_DIR,
    OP_STA,
    OP_LDB_DIR,
    OP_ANDB,
    OP_STB,
    OP_BITA,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] idx;
    logic [7:0]        imm;
  } q_entry_t;

  // direct address wrapped into the store, by restoring subtraction
  function automatic logic [ADDR_W-1:0] store_index(input logic [7:0] addr);
    logic [11:0] rem;
    rem = {4'b0, addr};
    for (int k = 3; k >= 0; k--) begin
      if (rem >= 12'(STORE_DEPTH << k)) begin
        rem = rem - 12'(STORE_DEPTH << k);
      end
    end
    return rem[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ design/cse_if.sv @@
`default_nettype none
interface cse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink (input valid, input opcode, input operand, output ready);
endinterface

interface cse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] acc_a_out;
  logic [7:0] acc_b_out;
  logic [7:0] flags_out;
  logic       status;

  modport source (output valid, output acc_a_out, output acc_b_out, output flags_out,
                  output status, input ready);
  modport sink (input valid, input acc_a_out, input acc_b_out, input flags_out,
                input status, output ready);
endinterface
`default_nettype wire

@@ design/cpu_subset_execute_unit.sv @@
// Executes a small subset of 8-bit accumulator instructions, one item per
// instruction (opcode byte plus operand byte), and returns A, B, the
// condition codes and a status for every item. The block accepts and
// retires one item per clock when the result side keeps taking items;
// an accepted item is decoded into the queue at the accepting edge, then
// read from the data store, then executed into the output register. The
// data store has one read port and one write port: a direct operand is
// read into a register and used when the item executes, and a store
// retiring in the same cycle as a read of the same address is forwarded.
// The data store reads as zero after reset through one valid bit per
// entry, so no clearing pass is needed and items are taken from the first
// cycle after reset. Unknown opcodes change nothing and return status 1.
`default_nettype none
module cpu_subset_execute_unit (
  input  logic      clk,
  input  logic      rst_n,
  cse_in_if.sink    in_ch,
  cse_out_if.source out_ch
);

  // front to queue
  logic              push_valid;
  logic              push_ready;
  cse_pkg::q_entry_t push_entry;

  // queue to back end
  logic              head_valid;
  logic              head_ready;
  cse_pkg::q_entry_t head_entry;

  // decode opcode and wrap the direct address
  cse_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // short queue so that front and back end stall independently
  cse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (head_valid),
    .pop_entry  (head_entry),
    .pop_ready  (head_ready)
  );

  // data-store read, execute and output register
  cse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .head_ready (head_ready),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

@@ design/cse_front.sv @@
`default_nettype none
module cse_front (
  cse_in_if.sink           in_ch,
  output logic             push_valid,
  output cse_pkg::q_entry_t push_entry,
  input  logic             push_ready
);

  cse_pkg::op_t op;

  always_comb begin
    case (in_ch.opcode)
      cse_pkg::OPC_LDA_IMM:  op = cse_pkg::OP_LDA_IMM;
      cse_pkg::OPC_LDA_DIR:  op = cse_pkg::OP_LDA_DIR;
      cse_pkg::OPC_STA_DIR:  op = cse_pkg::OP_STA;
      cse_pkg::OPC_LDB_DIR:  op = cse_pkg::OP_LDB_DIR;
      cse_pkg::OPC_ANDB_IMM: op = cse_pkg::OP_ANDB;
      cse_pkg::OPC_STB_DIR:  op = cse_pkg::OP_STB;
      cse_pkg::OPC_BITA_IMM: op = cse_pkg::OP_BITA;
      default:               op = cse_pkg::OP_BAD;
    endcase
  end

  assign push_entry.op  = op;
  assign push_entry.idx = cse_pkg::store_index(in_ch.operand);
  assign push_entry.imm = in_ch.operand;
  assign push_valid     = in_ch.valid;
  assign in_ch.ready    = push_ready;

endmodule
`default_nettype wire

@@ design/cse_queue.sv @@
`default_nettype none
module cse_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  cse_pkg::q_entry_t push_entry,
  output logic              push_ready,
  output logic              pop_valid,
  output cse_pkg::q_entry_t pop_entry,
  input  logic              pop_ready
);

  cse_pkg::q_entry_t               slot_r [cse_pkg::QDEPTH];
  logic [cse_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [cse_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [cse_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                            do_push, do_pop;

  assign push_ready = (count_r != cse_pkg::QCNT_W'(cse_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == cse_pkg::QPTR_W'(cse_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == cse_pkg::QPTR_W'(cse_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

@@ design/cse_back.sv @@
`default_nettype none
module cse_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  cse_pkg::q_entry_t head_entry,
  output logic              head_ready,
  cse_out_if.source         out_ch
);

  // data store with one valid bit per entry
  logic [7:0]                 mem [cse_pkg::STORE_DEPTH];
  logic [cse_pkg::STORE_DEPTH-1:0] mem_vld_r;

  // read stage
  logic              s1_valid_r, s1_valid_nxt;
  cse_pkg::q_entry_t s1_r;
  logic [7:0]        rd_data_r;
  logic              rd_vld_r;
  logic              fwd_r;
  logic [7:0]        fwd_data_r;

  // architectural state
  logic [7:0] acc_a_r, acc_a_nxt;
  logic [7:0] acc_b_r, acc_b_nxt;
  logic [7:0] cc_r, cc_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_a_r, out_b_r, out_cc_r;
  logic       out_st_r;

  logic       exec, s1_load, fwd_hit;
  logic       we, upd_nz, status;
  logic [7:0] ld_val, nz_val, wdata;

  assign exec       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign s1_load    = head_valid && (!s1_valid_r || exec);
  assign head_ready = !s1_valid_r || exec;

  // a store retiring this cycle hits the address being read now
  assign fwd_hit = exec && we && (s1_r.idx == head_entry.idx);

  assign ld_val = fwd_r ? fwd_data_r : (rd_vld_r ? rd_data_r : 8'h00);

  always_comb begin
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    we        = 1'b0;
    wdata     = acc_a_r;
    upd_nz    = 1'b1;
    nz_val    = 8'h00;
    status    = cse_pkg::STATUS_OK;
    case (s1_r.op)
      cse_pkg::OP_LDA_IMM: begin
        acc_a_nxt = s1_r.imm;
        nz_val    = s1_r.imm;
      end
      cse_pkg::OP_LDA_DIR: begin
        acc_a_nxt = ld_val;
        nz_val    = ld_val;
      end
      cse_pkg::OP_STA: begin
        we     = 1'b1;
        wdata  = acc_a_r;
        nz_val = acc_a_r;
      end
      cse_pkg::OP_LDB_DIR: begin
        acc_b_nxt = ld_val;
        nz_val    = ld_val;
      end
      cse_pkg::OP_ANDB: begin
        acc_b_nxt = acc_b_r & s1_r.imm;
        nz_val    = acc_b_r & s1_r.imm;
      end
      cse_pkg::OP_STB: begin
        we     = 1'b1;
        wdata  = acc_b_r;
        nz_val = acc_b_r;
      end
      cse_pkg::OP_BITA: begin
        nz_val = acc_a_r & s1_r.imm;
      end
      default: begin
        upd_nz = 1'b0;
        status = cse_pkg::STATUS_BAD_OP;
      end
    endcase
    cc_nxt = cc_r;
    if (upd_nz) begin
      cc_nxt[cse_pkg::FLAG_N_BIT] = nz_val[cse_pkg::SIGN_BIT];
      cc_nxt[cse_pkg::FLAG_Z_BIT] = (nz_val == 8'h00);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (exec) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_a_r     <= '0;
      acc_b_r     <= '0;
      cc_r        <= '0;
      mem_vld_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        acc_a_r <= acc_a_nxt;
        acc_b_r <= acc_b_nxt;
        cc_r    <= cc_nxt;
        if (we) begin
          mem_vld_r[s1_r.idx] <= 1'b1;
        end
      end
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (exec && we) begin
      mem[s1_r.idx] <= wdata;
    end
    if (s1_load) begin
      rd_data_r <= mem[head_entry.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r       <= head_entry;
      rd_vld_r   <= mem_vld_r[head_entry.idx];
      fwd_r      <= fwd_hit;
      fwd_data_r <= wdata;
    end
    if (exec) begin
      out_a_r  <= acc_a_nxt;
      out_b_r  <= acc_b_nxt;
      out_cc_r <= cc_nxt;
      out_st_r <= status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.acc_a_out = out_a_r;
  assign out_ch.acc_b_out = out_b_r;
  assign out_ch.flags_out = out_cc_r;
  assign out_ch.status    = out_st_r;

endmodule
`default_nettype wire
